/* sv/assert_macros.svh */
// Assertion helpers included by the RTL file gaussian_blur_3x3.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

/* sv/gbl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gbl_pkg;

  // Default geometry limits
  localparam int GBL_MAX_WIDTH  = 1024;
  localparam int GBL_PIXEL_BITS = 8;

  // Configuration port
  localparam int CFG_IDX_BITS    = 4;
  localparam int CFG_DATA_BITS   = 16;
  localparam int CFG_WIDTH_BITS  = 11;
  localparam int CFG_HEIGHT_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 4'd1;

  localparam logic [CFG_WIDTH_BITS-1:0]  RESET_WIDTH  = 11'd640;
  localparam logic [CFG_HEIGHT_BITS-1:0] RESET_HEIGHT = 16'd480;

  // Input item
  typedef struct packed {
    logic [7:0] pixel_in;
    logic       frame_start;
  } gbl_in_t;

  // Result item
  typedef struct packed {
    logic [7:0] pixel_out;
    logic       row_end;
    logic       frame_end;
  } gbl_out_t;

  // Per-item control carried alongside the line store read
  typedef struct packed {
    logic emit;
    logic row_end;
    logic frame_end;
  } gbl_ctrl_t;

endpackage

`default_nettype wire

/* sv/gbl_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module gbl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, and register the read (old data on a same-address collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/gbl_window.sv */
`timescale 1ns / 1ps
`default_nettype none

module gbl_window #(
  parameter int PIXEL_BITS = gbl_pkg::GBL_PIXEL_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  wire gbl_pkg::gbl_ctrl_t    ctrl_i,
  input  wire logic [PIXEL_BITS-1:0] top_i,
  input  wire logic [PIXEL_BITS-1:0] mid_i,
  input  wire logic [PIXEL_BITS-1:0] pix_i,
  output logic                       push_o,
  output gbl_pkg::gbl_out_t          data_o
);

  import gbl_pkg::*;

  localparam int SW = PIXEL_BITS + 4;

  // Columns c-2 (0..2) and c-1 (3..5), top to bottom
  logic [PIXEL_BITS-1:0] win_q [6];

  logic [SW-1:0]         col_top, col_mid, col_bot;
  logic [SW-1:0]         sum, rounded;
  logic [PIXEL_BITS-1:0] blurred;

  // Weight each row 1-2-1, then the rows 1-2-1
  always_comb begin
    col_top = SW'(win_q[0]) + (SW'(win_q[3]) << 1) + SW'(top_i);
    col_mid = SW'(win_q[1]) + (SW'(win_q[4]) << 1) + SW'(mid_i);
    col_bot = SW'(win_q[2]) + (SW'(win_q[5]) << 1) + SW'(pix_i);
    sum     = col_top + (col_mid << 1) + col_bot;
    rounded = sum + SW'(8);
    blurred = rounded[SW-1:4];
  end

  // Shift the window by one column per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (valid_i) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_i;
      win_q[4] <= mid_i;
      win_q[5] <= pix_i;
    end
  end

  assign push_o           = valid_i && ctrl_i.emit;
  assign data_o.pixel_out = 8'(blurred);
  assign data_o.row_end   = ctrl_i.row_end;
  assign data_o.frame_end = ctrl_i.frame_end;

endmodule

`default_nettype wire

/* sv/gbl_out_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module gbl_out_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire gbl_pkg::gbl_out_t data_i,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output gbl_pkg::gbl_out_t      data_o,
  output logic [1:0]             level_o
);

  import gbl_pkg::*;

  gbl_out_t   ent_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] level_q;
  logic       pop;

  assign pop = pop_i && (level_q != 2'd0);

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= data_i;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      level_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop) begin
        rptr_q <= !rptr_q;
      end
      level_q <= level_q + 2'(push_i) - 2'(pop);
    end
  end

  assign valid_o = (level_q != 2'd0);
  assign data_o  = ent_q[rptr_q];
  assign level_o = level_q;

endmodule

`default_nettype wire

/* sv/gaussian_blur_3x3.sv */
`timescale 1ns / 1ps
`default_nettype none

// 3x3 Gaussian blur (1-2-1 / 2-4-2 / 1-2-1, divide by 16, round half up) on a
// raster stream of single-channel pixels, valid convolution only.
// Input channel: in_valid_i / in_ready_o with in_data_i (pixel, frame_start).
// frame_start on an item puts the position back to column 0, row 0.
// Output channel: out_valid_o / out_ready_i with out_data_o (pixel, row_end,
// frame_end); a frame of W x H gives (W-2) x (H-2) items, border pixels none.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 image_width, 1 image_height); write only while the block is idle.
// An accepted item is registered in stage one and then in the output queue,
// whose fill level drives out_valid_o; only then can its result be taken.
// Throughput: one item per cycle while in_ready_o is high, set by the line
// store, a single memory read at acceptance and written back in the next cycle;
// a read that hits the entry being written is forwarded from the write data.
// A two-entry output queue decouples the sides: when the receiver stalls,
// in_ready_o drops once the queue and stage one hold two items between them.
// Reset: width 640, height 480, position and window zero, queue empty. The
// line stores hold no defined contents until written; no clearing pass.
module gaussian_blur_3x3 #(
  parameter int MAX_WIDTH  = gbl_pkg::GBL_MAX_WIDTH,
  parameter int PIXEL_BITS = gbl_pkg::GBL_PIXEL_BITS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire gbl_pkg::gbl_in_t                   in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output gbl_pkg::gbl_out_t                       out_data_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [gbl_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [gbl_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  import gbl_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PB = PIXEL_BITS;

  // Configuration
  logic [CFG_WIDTH_BITS-1:0]  cfg_width_q;
  logic [CFG_HEIGHT_BITS-1:0] cfg_height_q;
  logic [CW:0]                w_eff;
  logic [CFG_HEIGHT_BITS-1:0] h_eff;

  // Position
  logic [CW-1:0]              col_q, col_d, c0;
  logic [CFG_HEIGHT_BITS-1:0] row_q, row_d, r0;
  logic                       last_col, last_row;

  // Stage one: line store read returned
  logic            s1_v_q;
  logic [CW-1:0]   s1_addr_q;
  logic [PB-1:0]   s1_pix_q;
  gbl_ctrl_t       s1_ctrl_q, ctrl0;
  logic            fwd_q, fwd_d;
  logic [2*PB-1:0] fwd_data_q;
  logic [2*PB-1:0] ram_rdata, rd_eff;
  logic [PB-1:0]   top, mid, pix0;

  logic       accept, push, pop, out_valid;
  logic [1:0] level;
  gbl_out_t   win_data;

  // Write configuration registers, ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= RESET_WIDTH;
      cfg_height_q <= RESET_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  cfg_width_q  <= cfg_data_i[CFG_WIDTH_BITS-1:0];
        CFG_IMAGE_HEIGHT: cfg_height_q <= cfg_data_i[CFG_HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp geometry
  always_comb begin
    if (cfg_width_q < CFG_WIDTH_BITS'(3)) begin
      w_eff = (CW+1)'(3);
    end else if (32'(cfg_width_q) > MAX_WIDTH) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(cfg_width_q);
    end
    h_eff = (cfg_height_q < CFG_HEIGHT_BITS'(3)) ? CFG_HEIGHT_BITS'(3) : cfg_height_q;
  end

  // Input handshake: room for stage one, the queue content and one more
  assign pop         = out_valid && out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (3'(level) + 3'(s1_v_q)) <= (pop ? 3'd2 : 3'd1);

  // Position of the item at the input
  always_comb begin
    c0       = in_data_i.frame_start ? '0 : col_q;
    r0       = in_data_i.frame_start ? '0 : row_q;
    pix0     = PB'(in_data_i.pixel_in);
    last_col = ({1'b0, c0} + (CW+1)'(1)) >= w_eff;
    last_row = ({1'b0, r0} + 17'd1) >= {1'b0, h_eff};
    col_d    = last_col ? '0 : c0 + CW'(1);
    if (last_col) begin
      row_d = last_row ? '0 : r0 + CFG_HEIGHT_BITS'(1);
    end else begin
      row_d = r0;
    end
    ctrl0.emit      = (r0 >= CFG_HEIGHT_BITS'(2)) && (c0 >= CW'(2));
    ctrl0.row_end   = last_col;
    ctrl0.frame_end = last_col && last_row;
  end

  // Advance position on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Forward the pending write when the next read hits the same column
  assign fwd_d = accept && s1_v_q && (s1_addr_q == c0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      fwd_q  <= 1'b0;
    end else begin
      s1_v_q <= accept;
      fwd_q  <= fwd_d;
    end
  end

  // Hold the item alongside its line store read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q <= c0;
      s1_pix_q  <= pix0;
      s1_ctrl_q <= ctrl0;
    end
    if (fwd_d) begin
      fwd_data_q <= {s1_pix_q, mid};
    end
  end

  // Upper half: row above, lower half: row two above
  assign rd_eff = fwd_q ? fwd_data_q : ram_rdata;
  assign mid    = rd_eff[2*PB-1:PB];
  assign top    = rd_eff[PB-1:0];

  gbl_ram #(
    .WIDTH (2 * PB),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_v_q),
    .waddr_i (s1_addr_q),
    .wdata_i ({s1_pix_q, mid}),
    .re_i    (accept),
    .raddr_i (c0),
    .rdata_o (ram_rdata)
  );

  gbl_window #(
    .PIXEL_BITS (PB)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_v_q),
    .ctrl_i  (s1_ctrl_q),
    .top_i   (top),
    .mid_i   (mid),
    .pix_i   (s1_pix_q),
    .push_o  (push),
    .data_o  (win_data)
  );

  gbl_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (win_data),
    .pop_i   (out_ready_i),
    .valid_o (out_valid),
    .data_o  (out_data_o),
    .level_o (level)
  );

  assign out_valid_o = out_valid;

  // Checks
  `include "assert_macros.svh"

  `ASSERT_NEVER(a_fifo_overflow, push && (level == 2'd2) && !pop, "output queue overflow")
  `ASSERT_CLK(a_fwd_needs_s1, fwd_q |-> s1_v_q, "forward without item in stage one")
  `ASSERT_CLK(a_stall_has_cause, !in_ready_o |-> (level != 2'd0 || s1_v_q), "needless stall")
  `ASSERT_CLK(a_fwd_same_col, fwd_q |-> (s1_addr_q == $past(s1_addr_q)), "forward column mismatch")

endmodule

`default_nettype wire
